FILE: hw/rtl/drrip_ship_stream_bypass_replacement_top_macros.svh
// assertion macros for the replacement block
// used by the top level; expects clk and rst_n in scope
`ifndef DRRIP_SHIP_STREAM_BYPASS_REPLACEMENT_TOP_MACROS_SVH
`define DRRIP_SHIP_STREAM_BYPASS_REPLACEMENT_TOP_MACROS_SVH

// implication checked on the same clock edge
`define RRPL_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rrpl check failed");

// implication checked at the next clock edge
`define RRPL_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rrpl check failed");

`endif

FILE: hw/rtl/rrpl_pkg.sv
// shared constants and types for the replacement block
// no dependencies
package rrpl_pkg;

    localparam int DEF_NUM_SETS       = 2048;
    localparam int DEF_NUM_WAYS       = 16;
    localparam int DEF_SIGNATURE_BITS = 6;
    localparam int DEF_LEADER_SETS    = 64;
    localparam int DEF_SELECTOR_BITS  = 10;

    localparam logic [1:0]  RRIP_DISTANT = 2'd3;
    localparam logic [1:0]  RRIP_LONG    = 2'd2;
    localparam logic [1:0]  RRIP_NEAR    = 2'd0;
    localparam logic [1:0]  REUSE_STRONG = 2'd2;
    localparam logic [1:0]  REUSE_INIT   = 2'd1;
    localparam logic [63:0] STRIDE_BYTES = 64'd64;
    localparam logic [2:0]  BRRIP_MASK   = 3'h7;
    localparam int          LINE_SHIFT   = 6;

    localparam logic [2:0]  SCORE_MAX = 3'sd3;
    localparam logic [2:0]  SCORE_MIN = 3'b100;

    localparam int          CFG_IDX_W     = 2;
    localparam int          CFG_DATA_W    = 16;
    localparam logic [1:0]  CFG_THRESHOLD = 2'd0;
    localparam logic [1:0]  CFG_PERIOD    = 2'd1;
    localparam logic [2:0]  THRESHOLD_RST = 3'd2;
    localparam logic [15:0] PERIOD_RST    = 16'd16384;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MAIN  = 7'b0000100,
        S_TRAIN = 7'b0001000,
        S_DECAY = 7'b0010000,
        S_SIGRD = 7'b0100000,
        S_INS   = 7'b1000000
    } state_t;

endpackage

FILE: hw/rtl/drrip_ship_stream_bypass_replacement_top.sv
// top level of the rrip / signature / stream-bypass replacement block
// depends on rrpl_pkg, rrpl_ram, rrpl_age and the macros header
`include "drrip_ship_stream_bypass_replacement_top_macros.svh"

// Takes one request while busy is low and returns one result on done, one
// cycle wide; the receiver cannot hold a result off. A victim request reads
// the set row, writes it back aged and gives its result; an update reads the
// row, trains a signature counter, decays all counters if the decay period
// is reached, reads the counter for the new signature, then writes the
// insertion and gives its result. busy falls together with done, so the next
// request can be taken at the edge that ends the result cycle. Per-set state
// lives in one memory row per set, read and written back once per request.
// After reset busy stays high while both memories are cleared; configuration
// writes are taken anytime.
module drrip_ship_stream_bypass_replacement_top
    import rrpl_pkg::*;
#(
    parameter int NUM_SETS       = DEF_NUM_SETS,
    parameter int NUM_WAYS       = DEF_NUM_WAYS,
    parameter int SIGNATURE_BITS = DEF_SIGNATURE_BITS,
    parameter int LEADER_SETS    = DEF_LEADER_SETS,
    parameter int SELECTOR_BITS  = DEF_SELECTOR_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cmd,
    input  logic [10:0]           set_index,
    input  logic [3:0]            way_index,
    input  logic [63:0]           phys_address,
    input  logic [63:0]           pc,
    input  logic                  was_hit,
    output logic                  done,
    output logic [3:0]            victim_way,
    output logic [1:0]            insert_position,
    output logic                  bypassed,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SET_W   = $clog2(NUM_SETS);
    localparam int WAY_W   = $clog2(NUM_WAYS);
    localparam int SB      = SIGNATURE_BITS;
    localparam int SIG_N   = 1 << SB;
    localparam int CLR_N   = (NUM_SETS > SIG_N) ? NUM_SETS : SIG_N;
    localparam int CLR_W   = $clog2(CLR_N + 1);
    localparam int DCY_W   = SB + 1;
    localparam int RR_W    = NUM_WAYS * 2;
    localparam int SG_W    = NUM_WAYS * SB;
    localparam int ROW_W   = 3 + 64 + SG_W + RR_W;
    localparam int SET_EXT = (SET_W > 11) ? SET_W : 11;
    localparam int WAY_EXT = (WAY_W > 4) ? WAY_W : 4;
    localparam logic [SELECTOR_BITS-1:0] SEL_MID = SELECTOR_BITS'(1 << (SELECTOR_BITS - 1));
    localparam logic [SELECTOR_BITS-1:0] SEL_MAX = '1;
    localparam logic [SET_W-1:0] LEAD_N = LEADER_SETS[SET_W-1:0];
    localparam logic [SET_W-1:0] SET_TOP = '1;

    state_t                state_reg, state_next;
    logic [CLR_W-1:0]      clr_idx_reg, clr_idx_next;
    logic [DCY_W-1:0]      dcy_idx_reg, dcy_idx_next;
    logic                  dcy_wr_reg, dcy_wr_next;
    logic [SB-1:0]         dcy_waddr_reg, dcy_waddr_next;
    logic                  cmd_reg;
    logic [SET_W-1:0]      set_reg;
    logic [WAY_W-1:0]      way_reg;
    logic [63:0]           addr_reg;
    logic [63:0]           pc_reg;
    logic                  hit_reg;
    logic [ROW_W-1:0]      row_reg, row_next;
    logic [SB-1:0]         train_addr_reg, train_addr_next;
    logic [2:0]            thr_reg;
    logic [15:0]           period_reg;
    logic [15:0]           count_reg, count_next;
    logic [SELECTOR_BITS-1:0] sel_reg, sel_next;
    logic                  done_reg, done_next;
    logic [3:0]            victim_reg, victim_next;
    logic [1:0]            ins_reg, ins_next;
    logic                  byp_reg, byp_next;

    logic                  accept;
    logic [SET_EXT-1:0]    set_ext;
    logic [WAY_EXT-1:0]    way_ext;
    logic                  m_we;
    logic [SET_W-1:0]      m_waddr;
    logic [ROW_W-1:0]      m_wdata;
    logic [SET_W-1:0]      m_raddr;
    logic [ROW_W-1:0]      m_rdata;
    logic                  r_we;
    logic [SB-1:0]         r_waddr;
    logic [1:0]            r_wdata;
    logic [SB-1:0]         r_raddr;
    logic [1:0]            r_rdata;
    logic [RR_W-1:0]       aged;
    logic [WAY_W-1:0]      vict;
    logic [WAY_EXT-1:0]    vict_ext;
    logic [SB-1:0]         sig;
    logic [63:0]           prev;
    logic [63:0]           delta;
    logic [2:0]            score;
    logic [2:0]            score_new;
    logic [SB-1:0]         old_sig;
    logic [15:0]           count_inc;
    logic                  srl;
    logic                  brl;
    logic                  brrip_sel;
    logic                  bypass;
    logic [1:0]            ins;
    logic [63:0]           mix;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign set_ext   = SET_EXT'(set_index);
    assign way_ext   = WAY_EXT'(way_index);
    assign vict_ext  = WAY_EXT'(vict);
    assign mix       = pc_reg ^ addr_reg;
    assign sig       = pc_reg[SB-1:0] ^ addr_reg[LINE_SHIFT +: SB];
    assign srl       = set_reg < LEAD_N;
    assign brl       = !srl && ((SET_TOP - set_reg) < LEAD_N);
    assign prev      = m_rdata[RR_W+SG_W +: 64];
    assign score     = m_rdata[RR_W+SG_W+64 +: 3];
    assign delta     = addr_reg - prev;
    assign old_sig   = m_rdata[RR_W + SB*way_reg +: SB];
    assign count_inc = count_reg + 16'd1;

    assign done            = done_reg;
    assign victim_way      = victim_reg;
    assign insert_position = ins_reg;
    assign bypassed        = byp_reg;

    rrpl_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_set_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    rrpl_ram #(.WIDTH(2), .DEPTH(SIG_N)) u_reuse_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    rrpl_age #(.NUM_WAYS(NUM_WAYS)) u_age (
        .rrip_in  (m_rdata[RR_W-1:0]),
        .rrip_out (aged),
        .victim   (vict)
    );

    always_comb
    begin
        score_new = score;
        if (delta == STRIDE_BYTES || delta == (64'd0 - STRIDE_BYTES))
        begin
            if ($signed(score) < $signed(SCORE_MAX))
            begin
                score_new = score + 3'd1;
            end
        end
        else if (delta != 64'd0)
        begin
            if (score != SCORE_MIN)
            begin
                score_new = score - 3'd1;
            end
        end

        if (srl)
        begin
            brrip_sel = 1'b0;
        end
        else if (brl)
        begin
            brrip_sel = 1'b1;
        end
        else
        begin
            brrip_sel = sel_reg < SEL_MID;
        end
        bypass = !hit_reg && mix[0] &&
                 ($signed(row_reg[RR_W+SG_W+64 +: 3]) >= $signed(thr_reg));
        if (bypass)
        begin
            ins = RRIP_DISTANT;
        end
        else if (r_rdata >= REUSE_STRONG)
        begin
            ins = RRIP_NEAR;
        end
        else if (brrip_sel)
        begin
            ins = ((mix[2:0] & BRRIP_MASK) == 3'd0) ? RRIP_NEAR : RRIP_LONG;
        end
        else
        begin
            ins = RRIP_LONG;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_idx_next    = clr_idx_reg;
        dcy_idx_next    = dcy_idx_reg;
        dcy_wr_next     = 1'b0;
        dcy_waddr_next  = dcy_waddr_reg;
        row_next        = row_reg;
        train_addr_next = train_addr_reg;
        count_next      = count_reg;
        sel_next        = sel_reg;
        done_next       = 1'b0;
        victim_next     = victim_reg;
        ins_next        = ins_reg;
        byp_next        = byp_reg;
        m_we            = 1'b0;
        m_waddr         = set_reg;
        m_wdata         = row_reg;
        m_raddr         = set_ext[SET_W-1:0];
        r_we            = 1'b0;
        r_waddr         = train_addr_reg;
        r_wdata         = REUSE_INIT;
        r_raddr         = sig;

        unique case (state_reg)
            S_CLEAR:
            begin
                m_we    = (clr_idx_reg < CLR_W'(NUM_SETS));
                m_waddr = clr_idx_reg[SET_W-1:0];
                m_wdata = '0;
                for (int i = 0; i < NUM_WAYS; i++)
                begin
                    m_wdata[2*i +: 2] = RRIP_LONG;
                end
                r_we    = (clr_idx_reg < CLR_W'(SIG_N));
                r_waddr = clr_idx_reg[SB-1:0];
                r_wdata = REUSE_INIT;
                clr_idx_next = clr_idx_reg + CLR_W'(1);
                if (clr_idx_reg == CLR_W'(CLR_N - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MAIN;
                end
            end
            S_MAIN:
            begin
                row_next = m_rdata;
                if (!cmd_reg)
                begin
                    m_we = 1'b1;
                    m_wdata = {m_rdata[ROW_W-1:RR_W], aged};
                    done_next   = 1'b1;
                    victim_next = vict_ext[3:0];
                    ins_next    = 2'd0;
                    byp_next    = 1'b0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    row_next[RR_W+SG_W +: 64]  = addr_reg;
                    row_next[RR_W+SG_W+64 +: 3] = score_new;
                    train_addr_next = hit_reg ? sig : old_sig;
                    r_raddr = hit_reg ? sig : old_sig;
                    if (hit_reg)
                    begin
                        if (srl && sel_reg != SEL_MAX)
                        begin
                            sel_next = sel_reg + 1'b1;
                        end
                        else if (brl && sel_reg != '0)
                        begin
                            sel_next = sel_reg - 1'b1;
                        end
                    end
                    state_next = S_TRAIN;
                end
            end
            S_TRAIN:
            begin
                r_we = 1'b1;
                if (hit_reg)
                begin
                    r_wdata = (r_rdata == RRIP_DISTANT) ? r_rdata : r_rdata + 2'd1;
                end
                else
                begin
                    r_wdata = (r_rdata == 2'd0) ? r_rdata : r_rdata - 2'd1;
                end
                if (count_inc >= period_reg)
                begin
                    count_next   = '0;
                    dcy_idx_next = '0;
                    state_next   = S_DECAY;
                end
                else
                begin
                    count_next = count_inc;
                    state_next = S_SIGRD;
                end
            end
            S_DECAY:
            begin
                r_raddr = dcy_idx_reg[SB-1:0];
                r_we    = dcy_wr_reg;
                r_waddr = dcy_waddr_reg;
                r_wdata = (r_rdata == 2'd0) ? r_rdata : r_rdata - 2'd1;
                if (dcy_idx_reg != DCY_W'(SIG_N))
                begin
                    dcy_wr_next    = 1'b1;
                    dcy_waddr_next = dcy_idx_reg[SB-1:0];
                    dcy_idx_next   = dcy_idx_reg + DCY_W'(1);
                end
                else
                begin
                    state_next = S_SIGRD;
                end
            end
            S_SIGRD:
            begin
                r_raddr    = sig;
                state_next = S_INS;
            end
            S_INS:
            begin
                m_we = 1'b1;
                m_wdata = row_reg;
                for (int i = 0; i < NUM_WAYS; i++)
                begin
                    if (way_reg == i[WAY_W-1:0])
                    begin
                        m_wdata[2*i +: 2]       = ins;
                        m_wdata[RR_W + SB*i +: SB] = sig;
                    end
                end
                done_next   = 1'b1;
                victim_next = 4'd0;
                ins_next    = ins;
                byp_next    = bypass;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_idx_reg   <= '0;
            dcy_idx_reg   <= '0;
            dcy_wr_reg    <= 1'b0;
            thr_reg       <= THRESHOLD_RST;
            period_reg    <= PERIOD_RST;
            count_reg     <= '0;
            sel_reg       <= SEL_MID;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            dcy_idx_reg <= dcy_idx_next;
            dcy_wr_reg  <= dcy_wr_next;
            count_reg   <= count_next;
            sel_reg     <= sel_next;
            done_reg    <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_THRESHOLD: thr_reg    <= cfg_data[2:0];
                    CFG_PERIOD:    period_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            set_reg  <= set_ext[SET_W-1:0];
            way_reg  <= way_ext[WAY_W-1:0];
            addr_reg <= phys_address;
            pc_reg   <= pc;
            hit_reg  <= was_hit;
        end
        row_reg        <= row_next;
        train_addr_reg <= train_addr_next;
        dcy_waddr_reg  <= dcy_waddr_next;
        victim_reg     <= victim_next;
        ins_reg        <= ins_next;
        byp_reg        <= byp_next;
    end

    `RRPL_ASSERT_NEXT(a_accept_busy, accept, busy)
    `RRPL_ASSERT_NOW(a_bypass_distant, done && bypassed, insert_position == RRIP_DISTANT)
    `RRPL_ASSERT_NOW(a_victim_clean, done && victim_way != 4'd0, insert_position == 2'd0 && !bypassed)
    `RRPL_ASSERT_NEXT(a_done_pulse, done, !done)

endmodule

FILE: hw/rtl/rrpl_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module rrpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/rrpl_age.sv
// ages one set's re-reference values and picks the victim way
// depends on rrpl_pkg
module rrpl_age
    import rrpl_pkg::*;
#(
    parameter int NUM_WAYS = DEF_NUM_WAYS
) (
    input  logic [NUM_WAYS*2-1:0]        rrip_in,
    output logic [NUM_WAYS*2-1:0]        rrip_out,
    output logic [$clog2(NUM_WAYS)-1:0]  victim
);

    logic       hi;
    logic       lo;
    logic [1:0] maxv;
    logic [1:0] gap;

    always_comb
    begin
        hi = 1'b0;
        lo = 1'b0;
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            hi = hi | rrip_in[2*i+1];
        end
        for (int i = 0; i < NUM_WAYS; i++)
        begin
            lo = lo | (rrip_in[2*i] & (rrip_in[2*i+1] == hi));
        end
        maxv = {hi, lo};
        gap  = RRIP_DISTANT - maxv;
        victim = '0;
        for (int i = NUM_WAYS - 1; i >= 0; i--)
        begin
            rrip_out[2*i +: 2] = rrip_in[2*i +: 2] + gap;
            if (rrip_in[2*i +: 2] == maxv)
            begin
                victim = i[$clog2(NUM_WAYS)-1:0];
            end
        end
    end

endmodule

FILE: sim/tb_drrip_ship_stream_bypass_replacement_top.sv
// testbench for the rrip / signature / stream-bypass replacement block
// drives directed and random requests, checks each result against a local predictor or a typed value
// depends on rrpl_pkg and drrip_ship_stream_bypass_replacement_top
`timescale 1ns / 1ps

module tb_drrip_ship_stream_bypass_replacement_top;
    import rrpl_pkg::*;

    localparam int SETS      = DEF_NUM_SETS;
    localparam int WAYS      = DEF_NUM_WAYS;
    localparam int SIG_N     = 1 << DEF_SIGNATURE_BITS;
    localparam int LEADERS   = DEF_LEADER_SETS;
    localparam int SEL_MIDPT = 1 << (DEF_SELECTOR_BITS - 1);
    localparam int SEL_TOP   = (1 << DEF_SELECTOR_BITS) - 1;
    localparam logic CMD_VICTIM = 1'b0;
    localparam logic CMD_UPDATE = 1'b1;
    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [3:0] way;
        logic [1:0] pos;
        logic       byp;
    } repl_result_t;

    typedef struct {
        logic        cmd;
        logic [10:0] set;
        logic [3:0]  way;
        logic [63:0] addr;
        logic [63:0] pc;
        logic        hit;
        bit          typed;
        repl_result_t res;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic cmd;
    logic [10:0] set_index;
    logic [3:0] way_index;
    logic [63:0] phys_address;
    logic [63:0] pc;
    logic was_hit;
    logic done;
    logic [3:0] victim_way;
    logic [1:0] insert_position;
    logic bypassed;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    drrip_ship_stream_bypass_replacement_top uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .set_index(set_index), .way_index(way_index), .phys_address(phys_address),
        .pc(pc), .was_hit(was_hit), .done(done), .victim_way(victim_way),
        .insert_position(insert_position), .bypassed(bypassed),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // predictor state
    logic [1:0]         rrv [SETS][WAYS];
    logic [5:0]         lsig [SETS][WAYS];
    logic [63:0]        prev_addr [SETS];
    logic signed [2:0]  score [SETS];
    logic [1:0]         reuse [SIG_N];
    int                 psel;
    logic [15:0]        upd_count;
    logic signed [2:0]  thr;
    logic [15:0]        period;

    repl_result_t pending_results[$];
    int mismatches;
    bit failed;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic repl_result_t predict_replacement(logic c, logic [10:0] s,
        logic [3:0] w, logic [63:0] a, logic [63:0] p, logic h);
        repl_result_t r;
        int maxv;
        logic [63:0] delta;
        logic [5:0] sg;
        bit srl;
        bit brl;
        bit brrip;
        r = '0;
        if (c == CMD_VICTIM)
        begin
            maxv = 0;
            for (int i = 0; i < WAYS; i++)
                if (rrv[s][i] > maxv) maxv = rrv[s][i];
            for (int i = 0; i < WAYS; i++)
                rrv[s][i] = rrv[s][i] + 2'(3 - maxv);
            for (int i = WAYS - 1; i >= 0; i--)
                if (rrv[s][i] == RRIP_DISTANT) r.way = 4'(i);
            return r;
        end
        delta = a - prev_addr[s];
        sg = 6'(p ^ (a >> LINE_SHIFT));
        srl = s < LEADERS;
        brl = !srl && (SETS - 1 - s < LEADERS);
        if (delta == STRIDE_BYTES || delta == -STRIDE_BYTES)
        begin
            if (score[s] < 3) score[s] = score[s] + 1;
        end
        else if (delta != 0)
        begin
            if (score[s] > -4) score[s] = score[s] - 1;
        end
        prev_addr[s] = a;
        if (h)
        begin
            if (reuse[sg] < 3) reuse[sg] = reuse[sg] + 1;
        end
        else if (reuse[lsig[s][w]] > 0)
            reuse[lsig[s][w]] = reuse[lsig[s][w]] - 1;
        upd_count = upd_count + 1;
        if (upd_count >= period)
        begin
            upd_count = 0;
            for (int i = 0; i < SIG_N; i++)
                if (reuse[i] > 0) reuse[i] = reuse[i] - 1;
        end
        if (h)
        begin
            if (srl && psel < SEL_TOP) psel++;
            else if (brl && psel > 0) psel--;
        end
        brrip = srl ? 1'b0 : (brl ? 1'b1 : (psel < SEL_MIDPT));
        r.byp = !h && (score[s] >= thr) && ((p[0] ^ a[0]) == 1'b1);
        if (r.byp) r.pos = RRIP_DISTANT;
        else if (reuse[sg] >= REUSE_STRONG) r.pos = RRIP_NEAR;
        else if (brrip && ((p[2:0] ^ a[2:0]) & BRRIP_MASK) == 0) r.pos = RRIP_NEAR;
        else r.pos = RRIP_LONG;
        rrv[s][w] = r.pos;
        lsig[s][w] = sg;
        return r;
    endfunction

    task automatic write_register(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_THRESHOLD) thr = val[2:0];
        else if (idx == CFG_PERIOD) period = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one request; start stays high across back-to-back requests
    task automatic issue_request(stim_row_t row);
        repl_result_t r;
        int gap;
        gap = $urandom_range(0, 99);
        gap = gap < 70 ? 0 : (gap < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40));
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        cmd <= row.cmd;
        set_index <= row.set;
        way_index <= row.way;
        phys_address <= row.addr;
        pc <= row.pc;
        was_hit <= row.hit;
        @(posedge clk);
        while (busy) @(posedge clk);
        r = predict_replacement(row.cmd, row.set, row.way, row.addr, row.pc, row.hit);
        pending_results.push_back(row.typed ? row.res : r);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        repl_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10) $display("result with no request pending");
            end
            else
            begin
                e = pending_results.pop_front();
                if (e.way !== victim_way || e.pos !== insert_position || e.byp !== bypassed)
                begin
                    failed = 1'b1;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp way %0d pos %0d byp %0d, got %0d %0d %0d",
                            e.way, e.pos, e.byp, victim_way, insert_position, bypassed);
                end
            end
        end
    end

    function automatic stim_row_t mk(logic c, int s, int w, logic [63:0] a,
        logic [63:0] p, logic h);
        stim_row_t row;
        row.cmd = c;
        row.set = 11'(s);
        row.way = 4'(w);
        row.addr = a;
        row.pc = p;
        row.hit = h;
        row.typed = 1'b0;
        row.res = '0;
        return row;
    endfunction

    function automatic stim_row_t mk_typed(stim_row_t row, int w, int p, int b);
        row.typed = 1'b1;
        row.res.way = 4'(w);
        row.res.pos = 2'(p);
        row.res.byp = 1'(b);
        return row;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic stim_row_t random_request(int hit_pct);
        stim_row_t row;
        int s;
        int pick;
        logic [63:0] a;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1: s = $urandom_range(0, LEADERS - 1);
            2, 3: s = $urandom_range(SETS - LEADERS, SETS - 1);
            4, 5, 6: s = 100 + $urandom_range(0, 5);
            7, 8: s = $urandom_range(0, 3) * 682;
            default: s = $urandom_range(0, SETS - 1);
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 6) a = prev_addr[s] + ($urandom_range(0, 1) ? 64'd64 : -64'd64);
        else if (pick < 7) a = prev_addr[s];
        else a = rand64();
        row = mk($urandom_range(0, 3) == 0 ? CMD_VICTIM : CMD_UPDATE, s,
            $urandom_range(0, WAYS - 1), a,
            $urandom_range(0, 1) ? rand64() : 64'($urandom_range(0, 15)),
            $urandom_range(0, 99) < hit_pct);
        return row;
    endfunction

    stim_row_t directed[$];
    int thr_list[5] = '{-4, 3, 0, 1, -1};
    int per_list[5] = '{1, 65535, 5, 0, 3};
    int hit_list[5] = '{50, 80, 20, 60, 40};

    initial
    begin
        for (int s = 0; s < SETS; s++)
        begin
            prev_addr[s] = '0;
            score[s] = '0;
            for (int w = 0; w < WAYS; w++)
            begin
                rrv[s][w] = RRIP_LONG;
                lsig[s][w] = '0;
            end
        end
        for (int i = 0; i < SIG_N; i++) reuse[i] = REUSE_INIT;
        psel = SEL_MIDPT;
        upd_count = '0;
        thr = THRESHOLD_RST;
        period = PERIOD_RST;
        mismatches = 0;
        failed = 1'b0;
        start = 1'b0;
        cmd = CMD_VICTIM;
        set_index = '0;
        way_index = '0;
        phys_address = '0;
        pc = '0;
        was_hit = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed.push_back(mk_typed(mk(CMD_VICTIM, 0, 0, 0, 0, 0), 0, 0, 0));
        directed.push_back(mk_typed(mk(CMD_VICTIM, 2047, 0, 0, 0, 0), 0, 0, 0));
        directed.push_back(mk_typed(mk(CMD_UPDATE, 10, 15, 0, 0, 0), 0, 2, 0));
        directed.push_back(mk_typed(mk(CMD_VICTIM, 10, 0, 0, 0, 0), 0, 0, 0));
        directed.push_back(mk(CMD_UPDATE, 20, 3, 64, 0, 0));
        directed.push_back(mk(CMD_UPDATE, 20, 4, 128, 0, 0));
        directed.push_back(mk(CMD_UPDATE, 20, 5, 192, 0, 1));
        directed.push_back(mk(CMD_UPDATE, 20, 6, 256, 1, 0));
        directed.push_back(mk(CMD_UPDATE, 20, 7, 192, 1, 0));
        directed.push_back(mk(CMD_UPDATE, 2047, 15, '1, '1, 1));
        directed.push_back(mk(CMD_UPDATE, 2047, 0, 64'h40, 64'h8, 0));
        directed.push_back(mk(CMD_UPDATE, 1984, 1, 64'h1000, 64'h0, 0));
        directed.push_back(mk(CMD_UPDATE, 63, 2, 64'h80, 64'h5, 1));
        directed.push_back(mk(CMD_UPDATE, 63, 2, 64'h80, 64'h5, 1));
        directed.push_back(mk(CMD_UPDATE, 300, 9, 64'h80, 64'h5, 0));
        directed.push_back(mk(CMD_UPDATE, 300, 8, 64'hdead_beef_0000_0000, 64'h3, 0));
        directed.push_back(mk(CMD_VICTIM, 20, 0, 0, 0, 0));
        directed.push_back(mk(CMD_VICTIM, 300, 0, 0, 0, 0));
        directed.push_back(mk(CMD_VICTIM, 2047, 0, 0, 0, 0));
        foreach (directed[i]) issue_request(directed[i]);
        drain_results();

        for (int ph = 0; ph < 5; ph++)
        begin
            write_register(CFG_THRESHOLD, 16'(thr_list[ph]));
            write_register(CFG_PERIOD, 16'(per_list[ph]));
            if (ph == 2) write_register(CFG_SPARE_A, 16'($urandom));
            if (ph == 4) write_register(CFG_SPARE_B, 16'hffff);
            for (int n = 0; n < 100; n++) issue_request(random_request(hit_list[ph]));
            drain_results();
        end

        if (!failed && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rrpl_pkg.sv
hw/rtl/rrpl_ram.sv
hw/rtl/rrpl_age.sv
hw/rtl/drrip_ship_stream_bypass_replacement_top.sv
sim/tb_drrip_ship_stream_bypass_replacement_top.sv
